/* sv/hslhsv_pkg.sv */
// ----------------------------------------------------------------------------
// hslhsv_pkg
// Shared constants and the hue triangle-wave function for the HSL/HSV to
// RGB converter.
// ----------------------------------------------------------------------------
package hslhsv_pkg;

  // Hue offsets of the green and blue channels
  localparam logic [7:0] HUE_OFS_GREEN = 8'h55;
  localparam logic [7:0] HUE_OFS_BLUE  = 8'haa;

  // Triangle wave apex and knee
  localparam logic signed [11:0] WAVE_TOP  = 12'sh2ff;
  localparam logic signed [11:0] WAVE_KNEE = 12'sh100;
  localparam logic signed [11:0] WAVE_SAT  = 12'sh0ff;

  // Lightness midpoint
  localparam logic signed [9:0] LEVEL_MID = 10'sh080;

  // Model select codes
  localparam logic MODEL_HSL = 1'b0;
  localparam logic MODEL_HSV = 1'b1;

  // Pipeline depth from accept to output register
  localparam int unsigned PIPE_DEPTH = 5;

  // Clamped triangle wave: clamp(|0x2ff - 6h| - 0x100, 0, 255)
  function automatic logic [7:0] hue_wave(input logic [7:0] h);
    logic [10:0]        six;
    logic signed [11:0] t;
    logic signed [11:0] mag;
    logic signed [11:0] m;
    logic [7:0]         res;
    six = {1'b0, h, 2'b00} + {2'b00, h, 1'b0};
    t   = WAVE_TOP - $signed({1'b0, six});
    mag = (t < 0) ? -t : t;
    m   = mag - WAVE_KNEE;
    if (m < 0) begin
      res = 8'h00;
    end else if (m > WAVE_SAT) begin
      res = 8'hff;
    end else begin
      res = m[7:0];
    end
    return res;
  endfunction

endpackage

/* sv/hslhsv_if.sv */
// ----------------------------------------------------------------------------
// hslhsv_in_if / hslhsv_out_if
// Valid/ready channels for hue-saturation-level words in and RGB words out.
// ----------------------------------------------------------------------------
interface hslhsv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue;
  logic [7:0] saturation;
  logic [7:0] level;

  modport source (output valid, output hue, output saturation, output level,
                  input ready);
  modport sink   (input valid, input hue, input saturation, input level,
                  output ready);
endinterface

interface hslhsv_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, output red, output green, output blue,
                  input ready);
  modport sink   (input valid, input red, input green, input blue,
                  output ready);
endinterface

/* sv/hslhsv_chan.sv */
// ----------------------------------------------------------------------------
// hslhsv_chan
// Five-stage datapath for one color channel: hue wave, shade multiply,
// shade add, saturation blend multiply, blend add.
// ----------------------------------------------------------------------------
module hslhsv_chan
  import hslhsv_pkg::*;
(
  input  logic       clk_i,
  input  logic       en_i,
  input  logic       model_i,
  input  logic [7:0] hue_i,
  input  logic [7:0] sat_i,
  input  logic [7:0] lvl_i,
  output logic [7:0] color_o
);

  // Stage 1: hue wave
  logic [7:0] c1_q, sat1_q, lvl1_q;
  logic       model1_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c1_q     <= hue_wave(hue_i);
      sat1_q   <= sat_i;
      lvl1_q   <= lvl_i;
      model1_q <= model_i;
    end
  end

  // Stage 2: shade multiply
  logic signed [9:0]  mul_a;
  logic signed [8:0]  mul_b;
  logic signed [9:0]  d_lvl;
  logic signed [17:0] p2_d;
  logic signed [17:0] p2_q;
  logic [7:0]         c2_q, sat2_q, lvl2_q;
  logic               model2_q;

  always_comb begin
    d_lvl = $signed({2'b00, lvl1_q}) - LEVEL_MID;
    if (model1_q == MODEL_HSV) begin
      mul_a = $signed({2'b00, lvl1_q});
      mul_b = $signed({1'b0, c1_q});
    end else begin
      mul_a = d_lvl;
      mul_b = (d_lvl < 0) ? $signed({1'b0, c1_q}) : $signed({1'b0, ~c1_q});
    end
    p2_d = 18'(mul_a) * 18'(mul_b);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p2_q     <= p2_d;
      c2_q     <= c1_q;
      sat2_q   <= sat1_q;
      lvl2_q   <= lvl1_q;
      model2_q <= model1_q;
    end
  end

  // Stage 3: shade add, floor shift by 7 (HSL) or 8 (HSV)
  logic signed [17:0] sh3;
  logic signed [17:0] sum3;
  logic [7:0]         c3_q, sat3_q, lvl3_q;

  always_comb begin
    if (model2_q == MODEL_HSV) begin
      sh3  = p2_q >>> 8;
      sum3 = sh3;
    end else begin
      sh3  = p2_q >>> 7;
      sum3 = $signed({10'b0, c2_q}) + sh3;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c3_q   <= sum3[7:0];
      sat3_q <= sat2_q;
      lvl3_q <= lvl2_q;
    end
  end

  // Stage 4: blend multiply by inverted saturation
  logic signed [8:0]  diff4;
  logic signed [8:0]  inv4;
  logic signed [17:0] p4_d;
  logic signed [17:0] p4_q;
  logic [7:0]         c4_q;

  always_comb begin
    diff4 = $signed({1'b0, lvl3_q}) - $signed({1'b0, c3_q});
    inv4  = $signed({1'b0, ~sat3_q});
    p4_d  = 18'(inv4) * 18'(diff4);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p4_q <= p4_d;
      c4_q <= c3_q;
    end
  end

  // Stage 5: blend add into the output register
  logic signed [17:0] sum5;
  logic [7:0]         c5_q;

  assign sum5 = $signed({10'b0, c4_q}) + (p4_q >>> 8);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c5_q <= sum5[7:0];
    end
  end

  assign color_o = c5_q;

endmodule

/* sv/hsl_hsv_to_rgb.sv */
// ----------------------------------------------------------------------------
// hsl_hsv_to_rgb
// HSL or HSV to 8-bit RGB color converter, one word per clock while rgb_o is not stalled.
// ----------------------------------------------------------------------------
// Usage:
//   hsx_i carries hue, saturation and level words; rgb_o returns red, green
//   and blue words, one result for each accepted input, in order.
//   cfg_we_i/cfg_wdata_i write the color model (0 HSL, 1 HSV); write it
//   only while the pipeline is empty. Each word carries its model along.
//   An accepted word passes through the five channel stages to rgb_o.
//   Throughput: 1 word per cycle while rgb_o is not stalled, through the five-stage
//   channel pipeline (two multiplies, each followed by its add, after the hue wave).
//   Stall: all stages advance together; when rgb_o holds a word that the
//   receiver does not take, the whole pipeline holds and hsx_i.ready drops.
//   Empty slots ahead of the output are not filled while the output holds.
//   Reset: clears the valid bits and sets the model to HSL.
// ----------------------------------------------------------------------------
module hsl_hsv_to_rgb
  import hslhsv_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic         cfg_wdata_i,
  hslhsv_in_if.sink    hsx_i,
  hslhsv_out_if.source rgb_o
);

  // Color model register
  logic model_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_q <= MODEL_HSL;
    end else if (cfg_we_i) begin
      model_q <= cfg_wdata_i;
    end
  end

  // Advance when the output word is empty or being taken
  logic                  en;
  logic [PIPE_DEPTH-1:0] v_q;

  assign en          = !v_q[PIPE_DEPTH-1] || rgb_o.ready;
  assign hsx_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[PIPE_DEPTH-2:0], hsx_i.valid};
    end
  end

  // Per-channel hue offsets
  logic [7:0] hue_g, hue_b;

  assign hue_g = hsx_i.hue - HUE_OFS_GREEN;
  assign hue_b = hsx_i.hue - HUE_OFS_BLUE;

  hslhsv_chan u_red (
    .clk_i   (clk_i),
    .en_i    (en),
    .model_i (model_q),
    .hue_i   (hsx_i.hue),
    .sat_i   (hsx_i.saturation),
    .lvl_i   (hsx_i.level),
    .color_o (rgb_o.red)
  );

  hslhsv_chan u_green (
    .clk_i   (clk_i),
    .en_i    (en),
    .model_i (model_q),
    .hue_i   (hue_g),
    .sat_i   (hsx_i.saturation),
    .lvl_i   (hsx_i.level),
    .color_o (rgb_o.green)
  );

  hslhsv_chan u_blue (
    .clk_i   (clk_i),
    .en_i    (en),
    .model_i (model_q),
    .hue_i   (hue_b),
    .sat_i   (hsx_i.saturation),
    .lvl_i   (hsx_i.level),
    .color_o (rgb_o.blue)
  );

  assign rgb_o.valid = v_q[PIPE_DEPTH-1];

  // Accepted word occupies the first stage
  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hsx_i.valid && hsx_i.ready) |=> v_q[0])
    else $error("accepted word missing from first stage");

  // Held pipeline keeps all valid bits
  a_hold_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !en |=> $stable(v_q))
    else $error("valid bits moved during stall");

  // Output valid follows the fourth stage when advancing
  a_out_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en |=> (rgb_o.valid == $past(v_q[PIPE_DEPTH-2])))
    else $error("output valid out of step with pipeline");

endmodule

/* tb/hsl_hsv_to_rgb_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsl_hsv_to_rgb_tb
// Self-checking bench for the HSL/HSV to RGB converter. Feeds hue,
// saturation and level words through a bursty sender, drains RGB words
// through a stalling receiver, and checks each one against an in-bench
// color conversion in both color models.
// ----------------------------------------------------------------------------
module hsl_hsv_to_rgb_tb;
  import hslhsv_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned HOLD_OFF_LEN = 300;
  localparam int unsigned HOLD_OFF_AT  = 200;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] saturation;
    logic [7:0] level;
  } hsx_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_word_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic cfg_wdata_i;

  hslhsv_in_if  hsx_bus ();
  hslhsv_out_if rgb_bus ();

  hsl_hsv_to_rgb uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .hsx_i       (hsx_bus),
    .rgb_o       (rgb_bus)
  );

  hsx_word_t   pixel_queue[$];
  rgb_word_t   rgb_expected[$];
  logic        model_q;
  logic        in_fire;
  int unsigned cycle_cnt;
  int unsigned err_cnt;
  int unsigned accepted_words;
  int unsigned checked_words;
  int unsigned hsl_words;
  int unsigned hsv_words;
  int unsigned input_stalls;
  int unsigned gap_left;
  int unsigned burst_left;
  int unsigned hold_left;
  bit          hold_done;
  int unsigned stall_mode;
  int unsigned stall_age;

  // --------------------------------------------------------------------------
  // Color conversion
  // --------------------------------------------------------------------------

  // Clamped triangle wave of one hue channel
  function automatic int hue_ramp(input logic [7:0] h);
    int t;
    t = 767 - 6 * int'(h);
    if (t < 0) begin
      t = -t;
    end
    t = t - 256;
    if (t < 0) begin
      t = 0;
    end
    if (t > 255) begin
      t = 255;
    end
    return t;
  endfunction

  // Apply level and saturation to one channel; >>> on int floors
  function automatic logic [7:0] shade_channel(input int base, input int lvl,
                                               input int sat, input logic model);
    int c;
    int d;
    c = base;
    if (model == MODEL_HSL) begin
      d = lvl - 128;
      if (d < 0) begin
        c = c + ((d * c) >>> 7);
      end else begin
        c = c + ((d * (255 - c)) >>> 7);
      end
    end else begin
      c = (lvl * c) >>> 8;
    end
    c = c + (((255 - sat) * (lvl - c)) >>> 8);
    return c[7:0];
  endfunction

  function automatic rgb_word_t convert_pixel(input hsx_word_t px, input logic model);
    rgb_word_t res;
    logic [7:0] hg;
    logic [7:0] hb;
    hg = px.hue - 8'h55;
    hb = px.hue - 8'haa;
    res.red   = shade_channel(hue_ramp(px.hue), px.level, px.saturation, model);
    res.green = shade_channel(hue_ramp(hg), px.level, px.saturation, model);
    res.blue  = shade_channel(hue_ramp(hb), px.level, px.saturation, model);
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Monitor: check output words, predict accepted input words, watch time
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : watch_words
    rgb_word_t got;
    rgb_word_t want;
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words outstanding",
               cycle_cnt, rgb_expected.size());
      $display("Some tests failed");
      $finish;
    end else if (rst_ni) begin
      // check an output word against the oldest prediction
      if (rgb_bus.valid && rgb_bus.ready) begin
        got = '{rgb_bus.red, rgb_bus.green, rgb_bus.blue};
        if (rgb_expected.size() == 0) begin
          $error("unexpected RGB word r=%0h g=%0h b=%0h", got.red, got.green, got.blue);
          err_cnt++;
        end else begin
          want = rgb_expected.pop_front();
          if (got.red !== want.red) begin
            $error("red: expected %0h, got %0h", want.red, got.red);
            err_cnt++;
          end
          if (got.green !== want.green) begin
            $error("green: expected %0h, got %0h", want.green, got.green);
            err_cnt++;
          end
          if (got.blue !== want.blue) begin
            $error("blue: expected %0h, got %0h", want.blue, got.blue);
            err_cnt++;
          end
          checked_words++;
        end
      end
      // predict the word accepted at this edge
      if (hsx_bus.valid && hsx_bus.ready) begin
        rgb_expected.push_back(convert_pixel(
          '{hsx_bus.hue, hsx_bus.saturation, hsx_bus.level}, model_q));
        accepted_words++;
        if (model_q == MODEL_HSL) begin
          hsl_words++;
        end else begin
          hsv_words++;
        end
      end
      if (hsx_bus.valid && !hsx_bus.ready) begin
        input_stalls++;
      end
    end
    in_fire <= rst_ni && hsx_bus.valid && hsx_bus.ready;
  end

  // --------------------------------------------------------------------------
  // Driver: send queued words in bursts with random gaps
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : drive_words
    hsx_word_t px;
    int unsigned pick;
    if (rst_ni && (!hsx_bus.valid || in_fire)) begin
      if (gap_left != 0 || pixel_queue.size() == 0) begin
        hsx_bus.valid <= 1'b0;
        if (gap_left != 0) begin
          gap_left = gap_left - 1;
        end
      end else begin
        px = pixel_queue.pop_front();
        hsx_bus.valid      <= 1'b1;
        hsx_bus.hue        <= px.hue;
        hsx_bus.saturation <= px.saturation;
        hsx_bus.level      <= px.level;
        if (burst_left <= 1) begin
          // end of burst: pick the next burst length and the gap after it
          burst_left = $urandom_range(1, 24);
          pick = $urandom_range(0, 9);
          if (pick < 5) begin
            gap_left = 0;
          end else if (pick < 8) begin
            gap_left = $urandom_range(1, 3);
          end else begin
            gap_left = $urandom_range(4, 12);
          end
        end else begin
          burst_left = burst_left - 1;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: stall on a changing pattern, with one long hold-off
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin : take_words
    if (!rst_ni) begin
      rgb_bus.ready <= 1'b0;
    end else if (hold_left != 0) begin
      rgb_bus.ready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (!hold_done && accepted_words >= HOLD_OFF_AT) begin
      // hold off long enough for the pipeline to fill and block its input
      rgb_bus.ready <= 1'b0;
      hold_left = HOLD_OFF_LEN;
      hold_done = 1'b1;
    end else begin
      if (stall_age == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_age  = $urandom_range(16, 96);
      end else begin
        stall_age = stall_age - 1;
      end
      case (stall_mode)
        0: begin
          rgb_bus.ready <= 1'b1;
        end
        1: begin
          rgb_bus.ready <= ($urandom_range(0, 1) == 1);
        end
        2: begin
          rgb_bus.ready <= (stall_age % 4 == 0);
        end
        default: begin
          rgb_bus.ready <= ($urandom_range(0, 4) != 0);
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Write the color model while the pipeline is empty
  task automatic write_model(input logic model);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= model;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    model_q = model;
  endtask

  // Wait until every queued word is accepted and every result is back
  task automatic drain_words();
    while (pixel_queue.size() != 0 || hsx_bus.valid) begin
      @(posedge clk_i);
    end
    while (rgb_expected.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (PIPE_DEPTH + 2) @(posedge clk_i);
  endtask

  task automatic queue_corners();
    logic [7:0] hues[8];
    hues = '{8'h00, 8'h2a, 8'h2b, 8'h55, 8'h80, 8'haa, 8'hd5, 8'hff};
    // hue sweep at full color, mid level
    foreach (hues[i]) begin
      pixel_queue.push_back('{hues[i], 8'hff, 8'h80});
    end
    // level extremes and around the lightness midpoint
    pixel_queue.push_back('{8'h00, 8'hff, 8'h00});
    pixel_queue.push_back('{8'h00, 8'hff, 8'hff});
    pixel_queue.push_back('{8'h40, 8'hff, 8'h7f});
    pixel_queue.push_back('{8'h40, 8'hff, 8'h81});
    // grey: zero saturation, then one word at half saturation
    pixel_queue.push_back('{8'h10, 8'h00, 8'h00});
    pixel_queue.push_back('{8'h10, 8'h00, 8'h80});
    pixel_queue.push_back('{8'h10, 8'h00, 8'hff});
    pixel_queue.push_back('{8'hc0, 8'h80, 8'h40});
    // fields at or near their extremes
    pixel_queue.push_back('{8'h00, 8'h00, 8'h00});
    pixel_queue.push_back('{8'hff, 8'hff, 8'hff});
    pixel_queue.push_back('{8'hff, 8'h00, 8'hff});
    pixel_queue.push_back('{8'h00, 8'hff, 8'h00});
    pixel_queue.push_back('{8'h55, 8'h01, 8'hfe});
    pixel_queue.push_back('{8'haa, 8'hfe, 8'h01});
  endtask

  // Mostly uniform words, some pinned to saturation or level extremes, mid level or hue steps of 0x2a
  task automatic queue_random(input int unsigned count);
    hsx_word_t px;
    repeat (count) begin
      px.hue        = 8'($urandom_range(0, 255));
      px.saturation = 8'($urandom_range(0, 255));
      px.level      = 8'($urandom_range(0, 255));
      case ($urandom_range(0, 7))
        0: px.saturation = ($urandom_range(0, 1) == 1) ? 8'hff : 8'h00;
        1: px.level      = ($urandom_range(0, 1) == 1) ? 8'hff : 8'h00;
        2: px.level      = 8'h80;
        3: px.hue        = 8'(8'h2a * $urandom_range(0, 6));
        default: ;
      endcase
      pixel_queue.push_back(px);
    end
  endtask

  task automatic run_phase(input logic model, input bit corners,
                           input int unsigned count);
    write_model(model);
    if (corners) begin
      queue_corners();
    end
    queue_random(count);
    drain_words();
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = 1'b0;
    hsx_bus.valid      = 1'b0;
    hsx_bus.hue        = 8'h00;
    hsx_bus.saturation = 8'h00;
    hsx_bus.level      = 8'h00;
    rgb_bus.ready      = 1'b0;
    model_q            = MODEL_HSL;
    in_fire            = 1'b0;
    cycle_cnt          = 0;
    err_cnt            = 0;
    accepted_words     = 0;
    checked_words      = 0;
    hsl_words          = 0;
    hsv_words          = 0;
    input_stalls       = 0;
    gap_left           = 0;
    burst_left         = 1;
    hold_left          = 0;
    hold_done          = 1'b0;
    stall_mode         = 0;
    stall_age          = 0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // alternate the models, each with corners first time round
    run_phase(MODEL_HSL, 1'b1, 375);
    run_phase(MODEL_HSV, 1'b1, 375);
    run_phase(MODEL_HSL, 1'b0, 230);
    run_phase(MODEL_HSV, 1'b0, 230);

    // let any stray word show up before closing
    repeat (PIPE_DEPTH * 4) @(posedge clk_i);

    $display("Checked %0d RGB words: %0d in HSL, %0d in HSV, over 4 model phases",
             checked_words, hsl_words, hsv_words);
    $display("Input held back for %0d cycles, including one long output hold-off",
             input_stalls);
    if (err_cnt == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/hslhsv_pkg.sv
sv/hslhsv_if.sv
sv/hslhsv_chan.sv
sv/hsl_hsv_to_rgb.sv
tb/hsl_hsv_to_rgb_tb.sv
